FILE: rtl/core/ptc_pkg.sv
`default_nettype none

package ptc_pkg;

    localparam int CAL_W    = 16;
    localparam int RAW_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int DT_W     = 25;
    localparam int MUL_W    = 42;
    localparam int SQD_W    = 48;
    localparam int TEMP_W   = 19;
    localparam int T2_W     = 17;
    localparam int WIDE_W   = 40;
    localparam int SQ_W     = 36;
    localparam int TC_W     = 21;
    localparam int TOUT_W   = 15;
    localparam int POUT_W   = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_SENSITIVITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_OFFSET        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY_TEMP_COEFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TEMP_COEFF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_TEMPERATURE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE_SLOPE      = 3'd5;

    localparam logic signed [TEMP_W-1:0] TEMP_BASE  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW  = -19'sd1500;
    localparam logic signed [TC_W-1:0]   TEMP_MIN   = -21'sd4000;
    localparam logic signed [TC_W-1:0]   TEMP_MAX   = 21'sd8500;
    localparam logic signed [30:0]       PRESS_MIN  = 31'sd1000;
    localparam logic signed [30:0]       PRESS_MAX  = 31'sd120000;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [WIDE_W-1:0] off;
        logic signed [WIDE_W-1:0] sens;
        logic [T2_W-1:0]          t2;
        logic [RAW_W-1:0]         d1;
    } t_first;

    typedef struct packed {
        logic signed [TC_W-1:0]   temp;
        logic signed [WIDE_W-1:0] off;
        logic signed [WIDE_W-1:0] sens;
        logic [RAW_W-1:0]         d1;
    } t_corr;

endpackage

`default_nettype wire

FILE: rtl/core/ptc_front.sv
`default_nettype none

module ptc_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_vld,
    input  wire ptc_pkg::t_cal            i_cal,
    input  wire logic [ptc_pkg::RAW_W-1:0] i_d1,
    input  wire logic [ptc_pkg::RAW_W-1:0] i_d2,
    output logic                          o_vld,
    output ptc_pkg::t_first               o_data
);
    import ptc_pkg::*;

    // stage 1: temperature difference
    logic                     r_vld1;
    logic signed [DT_W-1:0]   r_dt;
    logic [RAW_W-1:0]         r_d1_1;
    logic signed [DT_W-1:0]   n_dt;

    // stage 2: products
    logic                     r_vld2;
    logic signed [MUL_W-1:0]  r_dtc6;
    logic signed [MUL_W-1:0]  r_c4dt;
    logic signed [MUL_W-1:0]  r_c3dt;
    logic [SQD_W-1:0]         r_dtsq;
    logic [RAW_W-1:0]         r_d1_2;
    logic signed [MUL_W-1:0]  n_dtc6;
    logic signed [MUL_W-1:0]  n_c4dt;
    logic signed [MUL_W-1:0]  n_c3dt;
    logic signed [SQD_W-1:0]  n_dtsq;

    // stage 3: first-order values
    logic                     r_vld3;
    t_first                   r_out;
    t_first                   n_out;
    logic signed [MUL_W-1:0]  w_b6;
    logic signed [MUL_W-1:0]  w_b4;
    logic signed [MUL_W-1:0]  w_b3;
    logic signed [MUL_W-1:0]  w_q6;
    logic signed [MUL_W-1:0]  w_q4;
    logic signed [MUL_W-1:0]  w_q3;

    function automatic logic [31:0] c2_shift(input logic [CAL_W-1:0] c);
        c2_shift = {c, 16'd0};
    endfunction

    assign n_dt = $signed({1'b0, i_d2}) - $signed({1'b0, i_cal.c5, 8'd0});

    assign n_dtc6 = MUL_W'(r_dt) * MUL_W'($signed({1'b0, i_cal.c6}));
    assign n_c4dt = MUL_W'(r_dt) * MUL_W'($signed({1'b0, i_cal.c4}));
    assign n_c3dt = MUL_W'(r_dt) * MUL_W'($signed({1'b0, i_cal.c3}));
    assign n_dtsq = SQD_W'(r_dt) * SQD_W'(r_dt);

    // divide by 2^k with truncation toward zero
    assign w_b6 = r_dtc6 + $signed({{(MUL_W-23){1'b0}}, {23{r_dtc6[MUL_W-1]}}});
    assign w_b4 = r_c4dt + $signed({{(MUL_W-7){1'b0}}, {7{r_c4dt[MUL_W-1]}}});
    assign w_b3 = r_c3dt + $signed({{(MUL_W-8){1'b0}}, {8{r_c3dt[MUL_W-1]}}});
    assign w_q6 = w_b6 >>> 23;
    assign w_q4 = w_b4 >>> 7;
    assign w_q3 = w_b3 >>> 8;

    always_comb begin
        n_out.temp = TEMP_BASE + w_q6[TEMP_W-1:0];
        n_out.off  = $signed({8'd0, c2_shift(i_cal.c2)}) + w_q4[WIDE_W-1:0];
        n_out.sens = $signed({9'd0, i_cal.c1, 15'd0}) + w_q3[WIDE_W-1:0];
        n_out.t2   = r_dtsq[47:31];
        n_out.d1   = r_d1_2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dt   <= n_dt;
            r_d1_1 <= i_d1;
            r_dtc6 <= n_dtc6;
            r_c4dt <= n_c4dt;
            r_c3dt <= n_c3dt;
            r_dtsq <= n_dtsq;
            r_d1_2 <= r_d1_1;
            r_out  <= n_out;
        end
    end

    assign o_vld  = r_vld3;
    assign o_data = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/ptc_second.sv
`default_nettype none

module ptc_second (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire ptc_pkg::t_first i_data,
    output logic                 o_vld,
    output ptc_pkg::t_corr       o_data
);
    import ptc_pkg::*;

    // stage 4: squares and thresholds
    logic                      r_vld4;
    t_first                    r_f;
    logic                      r_low;
    logic                      r_vlow;
    logic [SQ_W-1:0]           r_sq1;
    logic [SQ_W-1:0]           r_sq2;
    logic signed [TEMP_W-1:0]  w_dm;
    logic signed [TEMP_W-1:0]  w_dp;
    logic signed [2*TEMP_W-1:0] n_sq1;
    logic signed [2*TEMP_W-1:0] n_sq2;

    // stage 5: corrected values
    logic                      r_vld5;
    t_corr                     r_out;
    t_corr                     n_out;
    logic [WIDE_W-1:0]         w_off2;
    logic [WIDE_W-1:0]         w_sens2;
    logic [WIDE_W-1:0]         w_a5;
    logic [WIDE_W-1:0]         w_a7;
    logic [WIDE_W-1:0]         w_a11;

    assign w_dm  = i_data.temp - TEMP_BASE;
    assign w_dp  = i_data.temp - TEMP_VLOW;
    assign n_sq1 = (2*TEMP_W)'(w_dm) * (2*TEMP_W)'(w_dm);
    assign n_sq2 = (2*TEMP_W)'(w_dp) * (2*TEMP_W)'(w_dp);

    assign w_a5  = {{(WIDE_W-SQ_W){1'b0}}, r_sq1} * WIDE_W'(5);
    assign w_a7  = {{(WIDE_W-SQ_W){1'b0}}, r_sq2} * WIDE_W'(7);
    assign w_a11 = {{(WIDE_W-SQ_W){1'b0}}, r_sq2} * WIDE_W'(11);

    always_comb begin
        w_off2  = '0;
        w_sens2 = '0;
        if (r_low) begin
            w_off2  = w_a5 >> 1;
            w_sens2 = w_a5 >> 2;
            if (r_vlow) begin
                w_off2  = w_off2 + w_a7;
                w_sens2 = w_sens2 + (w_a11 >> 1);
            end
        end
        n_out.temp = TC_W'(r_f.temp) - (r_low ? $signed({4'd0, r_f.t2}) : '0);
        n_out.off  = r_f.off - $signed(w_off2);
        n_out.sens = r_f.sens - $signed(w_sens2);
        n_out.d1   = r_f.d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else if (i_en) begin
            r_vld4 <= i_vld;
            r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f    <= i_data;
            r_low  <= (i_data.temp < TEMP_BASE);
            r_vlow <= (i_data.temp < TEMP_VLOW);
            r_sq1  <= n_sq1[SQ_W-1:0];
            r_sq2  <= n_sq2[SQ_W-1:0];
            r_out  <= n_out;
        end
    end

    assign o_vld  = r_vld5;
    assign o_data = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/ptc_press.sv
`default_nettype none

module ptc_press (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_vld,
    input  wire ptc_pkg::t_corr             i_data,
    output logic                            o_vld,
    output logic [ptc_pkg::TOUT_W-1:0]      o_temp,
    output logic [ptc_pkg::POUT_W-1:0]      o_press,
    output logic                            o_clamped
);
    import ptc_pkg::*;

    localparam int PH_W   = 45;
    localparam int PL_W   = 44;
    localparam int PROD_W = 65;
    localparam int X_W    = PROD_W - 21;
    localparam int Y_W    = 46;
    localparam int P_W    = Y_W - 15;

    // stage 6: partial products, temperature saturation
    logic                      r_vld6;
    logic signed [PH_W-1:0]    r_ph;
    logic [PL_W-1:0]           r_pl;
    logic signed [WIDE_W-1:0]  r_off6;
    logic [TOUT_W-1:0]         r_t6;
    logic                      r_tc6;
    logic signed [PH_W-1:0]    n_ph;
    logic [TOUT_W-1:0]         n_t6;
    logic                      n_tc6;

    // stage 7: sum and offset
    logic                      r_vld7;
    logic signed [Y_W-1:0]     r_y;
    logic [TOUT_W-1:0]         r_t7;
    logic                      r_tc7;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_pb;
    logic signed [PROD_W-1:0]  w_x;

    // stage 8: scale, saturate, output register
    logic                      r_vld8;
    logic [TOUT_W-1:0]         r_t8;
    logic [POUT_W-1:0]         r_p8;
    logic                      r_c8;
    logic signed [Y_W-1:0]     w_yb;
    logic signed [Y_W-1:0]     w_yq;
    logic signed [P_W-1:0]     w_p;
    logic [POUT_W-1:0]         n_p8;
    logic                      n_pc;

    assign n_ph = PH_W'($signed({1'b0, i_data.d1})) * PH_W'($signed(i_data.sens[WIDE_W-1:20]));

    always_comb begin
        n_tc6 = 1'b0;
        n_t6  = i_data.temp[TOUT_W-1:0];
        if (i_data.temp < TEMP_MIN) begin
            n_t6  = TEMP_MIN[TOUT_W-1:0];
            n_tc6 = 1'b1;
        end
        if (i_data.temp > TEMP_MAX) begin
            n_t6  = TEMP_MAX[TOUT_W-1:0];
            n_tc6 = 1'b1;
        end
    end

    assign w_prod = $signed({r_ph, 20'd0}) + $signed({21'd0, r_pl});
    assign w_pb   = w_prod + $signed({{(PROD_W-21){1'b0}}, {21{w_prod[PROD_W-1]}}});
    assign w_x    = w_pb >>> 21;

    assign w_yb = r_y + $signed({{(Y_W-15){1'b0}}, {15{r_y[Y_W-1]}}});
    assign w_yq = w_yb >>> 15;
    assign w_p  = w_yq[P_W-1:0];

    always_comb begin
        n_pc = 1'b0;
        n_p8 = w_p[POUT_W-1:0];
        if (w_p < PRESS_MIN) begin
            n_p8 = PRESS_MIN[POUT_W-1:0];
            n_pc = 1'b1;
        end
        if (w_p > PRESS_MAX) begin
            n_p8 = PRESS_MAX[POUT_W-1:0];
            n_pc = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
            r_vld8 <= 1'b0;
        end else if (i_en) begin
            r_vld6 <= i_vld;
            r_vld7 <= r_vld6;
            r_vld8 <= r_vld7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph   <= n_ph;
            r_pl   <= PL_W'(i_data.d1) * PL_W'(i_data.sens[19:0]);
            r_off6 <= i_data.off;
            r_t6   <= n_t6;
            r_tc6  <= n_tc6;
            r_y    <= Y_W'($signed(w_x[X_W-1:0])) - Y_W'(r_off6);
            r_t7   <= r_t6;
            r_tc7  <= r_tc6;
            r_t8   <= r_t7;
            r_p8   <= n_p8;
            r_c8   <= r_tc7 | n_pc;
        end
    end

    assign o_vld     = r_vld8;
    assign o_temp    = r_t8;
    assign o_press   = r_p8;
    assign o_clamped = r_c8;

endmodule

`default_nettype wire

FILE: rtl/core/pressure_temperature_compensation.sv
// An accepted input transaction reaches the output after passing through every register stage.
// Throughput: one transaction per cycle while the pipeline is not held; eight register stages, all advancing together.
// The whole pipeline holds while the output register is full and not taken.
// Reset (synchronous, active low) clears all valid bits and the six calibration words.
`default_nettype none

module pressure_temperature_compensation (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ptc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ptc_pkg::CAL_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [ptc_pkg::RAW_W-1:0]     i_raw_pressure,
    input  wire logic [ptc_pkg::RAW_W-1:0]     i_raw_temperature,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [ptc_pkg::TOUT_W-1:0]         o_temperature_centi,
    output logic [ptc_pkg::POUT_W-1:0]         o_pressure_pa,
    output logic                               o_clamped
);
    import ptc_pkg::*;

    t_cal   r_cal;
    logic   w_en;
    logic   w_vld_f;
    logic   w_vld_s;
    t_first w_first;
    t_corr  w_corr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRESSURE_SENSITIVITY:   r_cal.c1 <= i_cfg_data;
                CFG_PRESSURE_OFFSET:        r_cal.c2 <= i_cfg_data;
                CFG_SENSITIVITY_TEMP_COEFF: r_cal.c3 <= i_cfg_data;
                CFG_OFFSET_TEMP_COEFF:      r_cal.c4 <= i_cfg_data;
                CFG_REFERENCE_TEMPERATURE:  r_cal.c5 <= i_cfg_data;
                CFG_TEMPERATURE_SLOPE:      r_cal.c6 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_en    = ~o_valid | i_ready;
    assign o_ready = w_en;

    ptc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_cal   (r_cal),
        .i_d1    (i_raw_pressure),
        .i_d2    (i_raw_temperature),
        .o_vld   (w_vld_f),
        .o_data  (w_first)
    );

    ptc_second u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld_f),
        .i_data  (w_first),
        .o_vld   (w_vld_s),
        .o_data  (w_corr)
    );

    ptc_press u_press (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (w_vld_s),
        .i_data    (w_corr),
        .o_vld     (o_valid),
        .o_temp    (o_temperature_centi),
        .o_press   (o_pressure_pa),
        .o_clamped (o_clamped)
    );

endmodule

`default_nettype wire

FILE: rtl/core/ptc_checker.sv
`default_nettype none

module ptc_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          o_ready,
    input  wire logic [ptc_pkg::RAW_W-1:0]     i_raw_pressure,
    input  wire logic [ptc_pkg::RAW_W-1:0]     i_raw_temperature,
    input  wire logic                          o_valid,
    input  wire logic                          i_ready,
    input  wire logic [ptc_pkg::TOUT_W-1:0]    o_temperature_centi,
    input  wire logic [ptc_pkg::POUT_W-1:0]    o_pressure_pa,
    input  wire logic                          o_clamped
);
    import ptc_pkg::*;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_raw_pressure)
            && $stable(i_raw_temperature))
        else $error("input changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_temperature_centi)
            && $stable(o_pressure_pa) && $stable(o_clamped))
        else $error("result changed while stalled");

    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input blocked while output drains");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_temperature_centi) >= -15'sd4000)
            && ($signed(o_temperature_centi) <= 15'sd8500))
        else $error("temperature out of range");

    a_press_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pressure_pa >= 17'd1000) && (o_pressure_pa <= 17'd120000))
        else $error("pressure out of range");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);

`default_nettype wire

FILE: sim/pressure_temperature_compensation_tb.sv
`default_nettype none

module pressure_temperature_compensation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptc_pkg::*;

    localparam int     NUM_CAL     = CFG_TEMPERATURE_SLOPE + 1;
    localparam int     STALL_LIMIT = 1000;
    localparam int     SETTLE      = 16;
    localparam longint SCALE_7     = 64'sd128;
    localparam longint SCALE_8     = 64'sd256;
    localparam longint SCALE_15    = 64'sd32768;
    localparam longint SCALE_16    = 64'sd65536;
    localparam longint SCALE_21    = 64'sd2097152;
    localparam longint SCALE_23    = 64'sd8388608;
    localparam longint SCALE_31    = 64'sd2147483648;
    localparam longint RAW_MAX     = 64'sd16777215;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {CAL_TYPICAL, CAL_RANDOM, CAL_EXTREME} cal_kind_t;

    typedef struct {
        logic [RAW_W-1:0] press_raw;
        logic [RAW_W-1:0] temp_raw;
    } conversion_t;

    typedef struct {
        logic [TOUT_W-1:0] temp;
        logic [POUT_W-1:0] press;
        logic              clamped;
    } reading_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CAL_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [RAW_W-1:0]     i_raw_pressure = '0;
    logic [RAW_W-1:0]     i_raw_temperature = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [TOUT_W-1:0]    o_temperature_centi;
    logic [POUT_W-1:0]    o_pressure_pa;
    logic                 o_clamped;

    logic [CAL_W-1:0] cal_shadow [0:NUM_CAL-1];
    conversion_t      conversion_q [$];
    reading_t         reading_q [$];
    int               error_count = 0;
    int               stall_cycles = 0;
    int               idle_odds = 0;
    int               send_gap = 0;
    int               recv_gap = 0;
    bit               send_taken = 1'b0;
    int               temp_targets [0:10] = '{8501, 8500, 2001, 2000, 1999, -1499, -1500,
                                              -1501, -4000, -4001, -12000};

    pressure_temperature_compensation uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_raw_pressure      (i_raw_pressure),
        .i_raw_temperature   (i_raw_temperature),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_pa       (o_pressure_pa),
        .o_clamped           (o_clamped)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic reading_t compensate(logic [RAW_W-1:0] press_raw,
                                            logic [RAW_W-1:0] temp_raw);
        reading_t r;
        longint   d1, d2, c1, c2, c3, c4, c5, c6;
        longint   dt, temp, off, sens, t2, off2, sens2, p, sq;
        d1 = longint'(press_raw);
        d2 = longint'(temp_raw);
        c1 = longint'(cal_shadow[CFG_PRESSURE_SENSITIVITY]);
        c2 = longint'(cal_shadow[CFG_PRESSURE_OFFSET]);
        c3 = longint'(cal_shadow[CFG_SENSITIVITY_TEMP_COEFF]);
        c4 = longint'(cal_shadow[CFG_OFFSET_TEMP_COEFF]);
        c5 = longint'(cal_shadow[CFG_REFERENCE_TEMPERATURE]);
        c6 = longint'(cal_shadow[CFG_TEMPERATURE_SLOPE]);
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        r.clamped = 1'b0;

        dt   = d2 - c5 * SCALE_8;
        temp = longint'(TEMP_BASE) + dt * c6 / SCALE_23;
        off  = c2 * SCALE_16 + c4 * dt / SCALE_7;
        sens = c1 * SCALE_15 + c3 * dt / SCALE_8;

        // second-order terms; both thresholds test the first-order temperature
        if (temp < longint'(TEMP_BASE)) begin
            t2    = dt * dt / SCALE_31;
            sq    = (temp - longint'(TEMP_BASE)) * (temp - longint'(TEMP_BASE));
            off2  = 5 * sq / 2;
            sens2 = 5 * sq / 4;
            if (temp < longint'(TEMP_VLOW)) begin
                sq    = (temp - longint'(TEMP_VLOW)) * (temp - longint'(TEMP_VLOW));
                off2  = off2 + 7 * sq;
                sens2 = sens2 + 11 * sq / 2;
            end
        end

        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p    = (d1 * sens / SCALE_21 - off) / SCALE_15;

        if (temp < longint'(TEMP_MIN)) begin
            temp = longint'(TEMP_MIN);
            r.clamped = 1'b1;
        end
        if (temp > longint'(TEMP_MAX)) begin
            temp = longint'(TEMP_MAX);
            r.clamped = 1'b1;
        end
        if (p < longint'(PRESS_MIN)) begin
            p = longint'(PRESS_MIN);
            r.clamped = 1'b1;
        end
        if (p > longint'(PRESS_MAX)) begin
            p = longint'(PRESS_MAX);
            r.clamped = 1'b1;
        end
        r.temp  = temp[TOUT_W-1:0];
        r.press = p[POUT_W-1:0];
        return r;
    endfunction

    function automatic logic [CAL_W-1:0] typical_cal(int idx);
        case (idx)
            CFG_PRESSURE_SENSITIVITY:   return 16'd40127;
            CFG_PRESSURE_OFFSET:        return 16'd36924;
            CFG_SENSITIVITY_TEMP_COEFF: return 16'd23317;
            CFG_OFFSET_TEMP_COEFF:      return 16'd23282;
            CFG_REFERENCE_TEMPERATURE:  return 16'd33464;
            default:                    return 16'd28312;
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] clip_raw(longint v);
        if (v < 0)
            return '0;
        if (v > RAW_MAX)
            return '1;
        return v[RAW_W-1:0];
    endfunction

    // raw temperature that lands the first-order temperature near a target
    function automatic logic [RAW_W-1:0] raw_for_temp(int target);
        longint ref_raw, slope;
        ref_raw = longint'(cal_shadow[CFG_REFERENCE_TEMPERATURE]) * SCALE_8;
        slope   = longint'(cal_shadow[CFG_TEMPERATURE_SLOPE]);
        if (slope == 0)
            return clip_raw(ref_raw);
        return clip_raw(ref_raw + (longint'(target) - longint'(TEMP_BASE)) * SCALE_23 / slope);
    endfunction

    function automatic conversion_t random_conversion();
        conversion_t c;
        longint      ref_raw, span;
        int          pick;
        ref_raw = longint'(cal_shadow[CFG_REFERENCE_TEMPERATURE]) * SCALE_8;
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            c.press_raw = RAW_W'($urandom);
        else
            c.press_raw = RAW_W'($urandom_range(6000000, 10000000));
        if (pick < 3) begin
            c.temp_raw = RAW_W'($urandom);
        end else if (pick < 8) begin
            span = longint'(1) << $urandom_range(0, 23);
            c.temp_raw = clip_raw(ref_raw + longint'($urandom_range(0, 32'(2 * span))) - span);
        end else begin
            c.temp_raw = clip_raw(longint'(raw_for_temp(temp_targets[$urandom_range(0, 10)]))
                                  + longint'($urandom_range(0, 600)) - 300);
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx <= CFG_TEMPERATURE_SLOPE)
            cal_shadow[idx] = data;
    endtask

    task automatic program_calibration(cal_kind_t kind);
        int               start, idx;
        logic [CAL_W-1:0] value;
        start = $urandom_range(0, NUM_CAL - 1);
        for (int k = 0; k < NUM_CAL; k++) begin
            idx = (start + k) % NUM_CAL;
            case (kind)
                CAL_TYPICAL: value = CAL_W'(typical_cal(idx) + $urandom_range(0, 4000) - 2000);
                CAL_RANDOM:  value = CAL_W'($urandom);
                default: begin
                    case ($urandom_range(0, 2))
                        0:       value = '0;
                        1:       value = '1;
                        default: value = CAL_W'($urandom);
                    endcase
                end
            endcase
            cfg_write(idx[CFG_IDX_W-1:0], value);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_conversion(logic [RAW_W-1:0] press_raw, logic [RAW_W-1:0] temp_raw);
        conversion_t c;
        c.press_raw = press_raw;
        c.temp_raw  = temp_raw;
        conversion_q.push_back(c);
    endtask

    // hold off until every result is back, then let the pipeline settle
    task automatic drain();
        while (conversion_q.size() != 0 || i_valid || reading_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic run_random(cal_kind_t kind, int count, int odds);
        program_calibration(kind);
        idle_odds = odds;
        repeat (count) conversion_q.push_back(random_conversion());
        drain();
    endtask

    // driver
    always @(negedge i_clk) begin : drive_in
        conversion_t c;
        if (send_taken || !i_valid) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (conversion_q.size() == 0) begin
                i_valid <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                send_gap = $urandom_range(0, 17);
                i_valid <= 1'b0;
            end else begin
                c = conversion_q.pop_front();
                i_raw_pressure    <= c.press_raw;
                i_raw_temperature <= c.temp_raw;
                i_valid           <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin : drive_ready
        if (recv_gap > 0) begin
            recv_gap--;
            i_ready <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            recv_gap = $urandom_range(0, 17);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin : watch_out
        reading_t want;
        bit       recv_taken;
        if (!i_rst_n) begin
            send_taken = 1'b0;
        end else begin
            send_taken = i_valid && o_ready;
            recv_taken = o_valid && i_ready;
            if (send_taken)
                reading_q.push_back(compensate(i_raw_pressure, i_raw_temperature));
            if (recv_taken) begin
                if (reading_q.size() == 0) begin
                    report_mismatch("unexpected transaction, temperature_centi",
                                    longint'($signed(o_temperature_centi)), 0);
                end else begin
                    want = reading_q.pop_front();
                    if (o_temperature_centi !== want.temp)
                        report_mismatch("temperature_centi", longint'($signed(o_temperature_centi)),
                                        longint'($signed(want.temp)));
                    if (o_pressure_pa !== want.press)
                        report_mismatch("pressure_pa", longint'(o_pressure_pa),
                                        longint'(want.press));
                    if (o_clamped !== want.clamped)
                        report_mismatch("clamped", longint'(o_clamped), longint'(want.clamped));
                end
            end
            if (send_taken || recv_taken) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        for (int k = 0; k < NUM_CAL; k++)
            cal_shadow[k] = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // uncalibrated block straight out of reset
        idle_odds = 4;
        push_conversion('0, '0);
        push_conversion('1, '1);
        push_conversion('0, '1);
        push_conversion('1, '0);
        drain();

        // nominal calibration, threshold sweep; spare indices must be ignored
        for (int k = 0; k < NUM_CAL; k++)
            cfg_write(k[CFG_IDX_W-1:0], typical_cal(k));
        cfg_write(CFG_SPARE_LO, '1);
        cfg_write(CFG_SPARE_HI, 16'h5A5A);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        idle_odds = 3;
        push_conversion('0, '0);
        push_conversion('1, '1);
        push_conversion('0, '1);
        push_conversion('1, '0);
        for (int k = 0; k <= 10; k++)
            push_conversion(24'd9085466, raw_for_temp(temp_targets[k]));
        push_conversion('0, raw_for_temp(-4001));
        push_conversion('1, raw_for_temp(-4001));
        push_conversion('1, raw_for_temp(8501));
        drain();

        // every word at full scale
        for (int k = 0; k < NUM_CAL; k++)
            cfg_write(k[CFG_IDX_W-1:0], '1);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        push_conversion('0, '0);
        push_conversion('1, '1);
        repeat (18) conversion_q.push_back(random_conversion());
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            case (phase % 5)
                1:       run_random(CAL_RANDOM, 80, 6);
                3:       run_random(CAL_EXTREME, 80, 12);
                4:       run_random(CAL_TYPICAL, 80, 0);
                default: run_random(CAL_TYPICAL, 80, 3);
            endcase
        end

        // closing stretch at full rate
        run_random(CAL_TYPICAL, 150, 0);

        if (reading_q.size() != 0)
            report_mismatch("results never delivered", longint'(reading_q.size()), 0);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
